/* hdl/operand_stack_arg_adjust_macros.svh */
// Assertion macros shared by the operand stack RTL.
`ifndef OPERAND_STACK_ARG_ADJUST_MACROS_SVH
`define OPERAND_STACK_ARG_ADJUST_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OSAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define OSAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/osaa_pkg.sv */
// Package with codes, widths and types of the operand stack.
package osaa_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int TAG_W     = 3;
  localparam int PAY_W     = 64;
  localparam int OFF_W     = 6;
  localparam int EXP_W     = 7;
  localparam int FILL_W    = 7;
  localparam int ERR_W     = 2;
  localparam int ACT_W     = 2;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 80;

  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_ADJUST = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_COUNT     = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PAY_W-1:0] payload;
    logic             found;
    logic [ERR_W-1:0] err;
  } res_t;

endpackage

/* hdl/osaa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module osaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/operand_stack_arg_adjust.sv */
// Operand stack of tagged entries with argument-count adjustment.
//
// Input channel s_axis: one transaction carries one operation (push, pop,
// peek at an offset below the top, or argument adjust), the code in tuser.
// Output channel m_axis: exactly one result transaction per operation, with
// the popped or peeked entry, the error code and the fill after the step;
// tuser marks a real entry.
// Entries live in one RAM with a registered read port.
// Steps per operation, from acceptance to the result register: a push
//   writes the RAM directly; pop and peek do one RAM read; adjust reads the
//   count, checks it and then the new fill, moves the kept entries and then
//   inserts any nulls. A failed push, pop or adjust on an empty stack and
//   a peek past the contents go straight to the result. Entries move one per
//   cycle over the single read and write port, each written in the cycle after its read.
// A new operation is taken the cycle after the previous result is loaded,
//   while that result may still wait in the output register.
// Reset empties the stack; RAM contents stay as they are and are never read
// above the fill. A stalled receiver holds the result register; the
// sequencer then waits with its next result and takes no new operation.
module operand_stack_arg_adjust
  import osaa_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // push_tag[2:0], push_payload[66:3], peek_offset[72:67], expected_count[79:73]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_tag[2:0], out_payload[66:3], error[68:67], fill[75:69], zero[79:76]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // found[0]
  output logic                 m_axis_tuser
);

  `include "operand_stack_arg_adjust_macros.svh"

  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NW    = ((CW > EXP_W) ? CW : EXP_W) + 1;
  localparam int CMPW  = ((PAYLOAD_BITS > CW) ? PAYLOAD_BITS : CW) + 1;
  localparam int ENT_W = TAG_W + PAYLOAD_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_PLAN  = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_NULL  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  // control state
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] top_q, top_d;
  logic [NW-1:0] copy_left_q, copy_left_d;
  logic [NW-1:0] null_left_q, null_left_d;
  logic          rd_pend_q, rd_pend_d;
  logic          out_valid_q, out_valid_d;

  // operation and working registers
  logic [ACT_W-1:0]        act_q, act_d;
  logic [TAG_W-1:0]        tag_q, tag_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [OFF_W-1:0]        off_q, off_d;
  logic [EXP_W-1:0]        exp_q, exp_d;
  logic [PAYLOAD_BITS-1:0] cnt_q, cnt_d;
  logic [CW-1:0]           cntc_q, cntc_d;
  logic [CW-1:0]           base_q, base_d;
  logic [PW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]           null_ptr_q, null_ptr_d;
  logic                    dir_down_q, dir_down_d;
  res_t                    res_q, res_d;
  res_t                    out_q, out_d;
  logic [FILL_W-1:0]       out_fill_q, out_fill_d;

  // RAM port
  logic             ram_we, ram_re;
  logic [PW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic [TAG_W-1:0]        rd_tag;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  // derived values
  logic [CW-1:0]                top_m1;
  logic [NW-1:0]                top_w, off_w, exp_w, n_w, cntc_w, base_w;
  logic [NW-1:0]                peek_idx_w, newfill_w, up_src_w, dn_src_w, dn_dst_w;
  logic [CMPW-1:0]              cnt_cmp, n_cmp;
  logic [CMPW+PAYLOAD_BITS-1:0] cnt_ext;
  logic [PAYLOAD_BITS+PAY_W-1:0] rd_pay_ext;
  logic [CW+FILL_W-1:0]         top_ext;
  logic                         in_fire, emit_fire;

  osaa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_tag = ram_rdata[ENT_W-1:PAYLOAD_BITS];
  assign rd_pay = ram_rdata[PAYLOAD_BITS-1:0];

  assign top_m1     = top_q - 1'b1;
  assign top_w      = NW'(top_q);
  assign off_w      = NW'(off_q);
  assign exp_w      = NW'(exp_q);
  assign n_w        = NW'(top_m1);
  assign cntc_w     = NW'(cntc_q);
  assign base_w     = NW'(base_q);
  assign peek_idx_w = top_w - 1'b1 - off_w;
  assign newfill_w  = base_w + exp_w;
  assign up_src_w   = n_w - exp_w;
  assign dn_src_w   = n_w - 1'b1;
  assign dn_dst_w   = newfill_w - 1'b1;

  assign cnt_ext    = {{CMPW{1'b0}}, cnt_q};
  assign cnt_cmp    = cnt_ext[CMPW-1:0];
  assign n_cmp      = CMPW'(top_m1);
  assign rd_pay_ext = {{PAY_W{1'b0}}, rd_pay};
  assign top_ext    = {{FILL_W{1'b0}}, top_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_fire     = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    copy_left_d = copy_left_q;
    null_left_d = null_left_q;
    rd_pend_d   = 1'b0;
    act_d       = act_q;
    tag_d       = tag_q;
    pay_d       = pay_q;
    off_d       = off_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    cntc_d      = cntc_q;
    base_d      = base_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    null_ptr_d  = null_ptr_q;
    dir_down_d  = dir_down_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_ptr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = rd_ptr_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_d   = s_axis_tuser;
          tag_d   = s_axis_tdata[TAG_W-1:0];
          pay_d   = s_axis_tdata[TAG_W +: PAYLOAD_BITS];
          off_d   = s_axis_tdata[TAG_W+PAY_W +: OFF_W];
          exp_d   = s_axis_tdata[TAG_W+PAY_W+OFF_W +: EXP_W];
          res_d   = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_EMIT;
        case (act_q)
          ACT_PUSH: begin
            if (top_q == CW'(DEPTH)) begin
              res_d.err = ERR_OVERFLOW;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = top_q[PW-1:0];
              ram_wdata = {tag_q, pay_q};
              top_d     = top_q + 1'b1;
            end
          end
          ACT_POP: begin
            if (top_q == '0) begin
              res_d.err = ERR_UNDERFLOW;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = top_m1[PW-1:0];
              top_d     = top_m1;
              state_d   = S_READ;
            end
          end
          ACT_PEEK: begin
            // past the contents: empty result, no error
            if (off_w < top_w) begin
              ram_re    = 1'b1;
              ram_raddr = peek_idx_w[PW-1:0];
              state_d   = S_READ;
            end
          end
          ACT_ADJUST: begin
            if (top_q == '0) begin
              res_d.err = ERR_UNDERFLOW;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = top_m1[PW-1:0];
              state_d   = S_READ;
            end
          end
          default: begin
            state_d = S_EMIT;
          end
        endcase
      end
      S_READ: begin
        if (act_q == ACT_ADJUST) begin
          cnt_d   = rd_pay;
          state_d = S_CHECK;
        end else begin
          res_d.tag     = rd_tag;
          res_d.payload = rd_pay_ext[PAY_W-1:0];
          res_d.found   = 1'b1;
          state_d       = S_EMIT;
        end
      end
      S_CHECK: begin
        if (cnt_cmp > n_cmp) begin
          res_d.err = ERR_COUNT;
          state_d   = S_EMIT;
        end else begin
          cntc_d  = cnt_cmp[CW-1:0];
          base_d  = top_m1 - cnt_cmp[CW-1:0];
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        if (newfill_w > NW'(DEPTH)) begin
          res_d.err = ERR_OVERFLOW;
          state_d   = S_EMIT;
        end else begin
          top_d       = newfill_w[CW-1:0];
          copy_left_d = '0;
          null_left_d = '0;
          null_ptr_d  = base_q[PW-1:0];
          state_d     = S_COPY;
          if (cntc_w > exp_w) begin
            // surplus: slide the top expected entries down over the gap
            copy_left_d = exp_w;
            dir_down_d  = 1'b0;
            rd_ptr_d    = up_src_w[PW-1:0];
            wr_ptr_d    = base_q[PW-1:0];
          end else if (cntc_w < exp_w) begin
            // shortfall: lift counted entries, highest first, then fill nulls
            copy_left_d = cntc_w;
            dir_down_d  = 1'b1;
            rd_ptr_d    = dn_src_w[PW-1:0];
            wr_ptr_d    = dn_dst_w[PW-1:0];
            null_left_d = exp_w - cntc_w;
          end
        end
      end
      S_COPY: begin
        // each entry is written in the cycle after the read that fetches it
        if (copy_left_q != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = rd_ptr_q;
          rd_pend_d   = 1'b1;
          copy_left_d = copy_left_q - 1'b1;
          rd_ptr_d    = dir_down_q ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
        end
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr_q;
          ram_wdata = ram_rdata;
          wr_ptr_d  = dir_down_q ? wr_ptr_q - 1'b1 : wr_ptr_q + 1'b1;
        end
        if ((copy_left_q == '0) && !rd_pend_q) begin
          state_d = (null_left_q != '0) ? S_NULL : S_EMIT;
        end
      end
      S_NULL: begin
        ram_we      = 1'b1;
        ram_waddr   = null_ptr_q;
        ram_wdata   = '0;
        null_ptr_d  = null_ptr_q + 1'b1;
        null_left_d = null_left_q - 1'b1;
        if (null_left_q == NW'(1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    out_fill_d  = out_fill_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
      out_fill_d  = top_ext[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      copy_left_q <= '0;
      null_left_q <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      copy_left_q <= copy_left_d;
      null_left_q <= null_left_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    tag_q      <= tag_d;
    pay_q      <= pay_d;
    off_q      <= off_d;
    exp_q      <= exp_d;
    cnt_q      <= cnt_d;
    cntc_q     <= cntc_d;
    base_q     <= base_d;
    rd_ptr_q   <= rd_ptr_d;
    wr_ptr_q   <= wr_ptr_d;
    null_ptr_q <= null_ptr_d;
    dir_down_q <= dir_down_d;
    res_q      <= res_d;
    out_q      <= out_d;
    out_fill_q <= out_fill_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {4'b0000, out_fill_q, out_q.err, out_q.payload, out_q.tag};

  `OSAA_ASSERT(a_fill_bound, top_q <= CW'(DEPTH), "stack fill above depth")
  `OSAA_ASSERT(a_rw_apart, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "read and write hit one entry")
  `OSAA_ASSERT_NEXT(a_push_grows, (state_q == S_EXEC) && (act_q == ACT_PUSH) && (top_q != CW'(DEPTH)), top_q == $past(top_q) + 1'b1, "push did not grow the stack")
  `OSAA_ASSERT(a_found_clean, (out_valid_q && out_q.found) |-> (out_q.err == ERR_NONE), "entry returned with an error")

endmodule

/* sim/tb_operand_stack_arg_adjust.sv */
// Testbench for the operand stack with argument-count adjustment.
`timescale 1ns / 100ps

module tb_operand_stack_arg_adjust;
  import osaa_pkg::*;

  localparam int DEPTH_N      = DEPTH_DEF;
  localparam int ITEMS        = 1050;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [TAG_W-1:0] TAG_NULL   = 3'd0;
  localparam logic [TAG_W-1:0] TAG_INT    = 3'd1;
  localparam logic [TAG_W-1:0] TAG_BOOL   = 3'd2;
  localparam logic [TAG_W-1:0] TAG_FLOAT  = 3'd3;
  localparam logic [TAG_W-1:0] TAG_STRING = 3'd4;
  localparam logic [TAG_W-1:0] TAG_OBJECT = 3'd5;
  localparam logic [TAG_W-1:0] TAG_SPARE6 = 3'd6;
  localparam logic [TAG_W-1:0] TAG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PAY_W-1:0]  payload;
    logic              found;
    logic [ERR_W-1:0]  err;
    logic [FILL_W-1:0] fill;
  } stack_out_t;

  // Mirror of the stack contents plus the queue of results still owed.
  class operand_stack_mirror;
    logic [TAG_W-1:0] tag_mem [DEPTH_N];
    logic [PAY_W-1:0] pay_mem [DEPTH_N];
    int unsigned      fill;
    stack_out_t       pending_results[$];
    int               failures;
    int               checked;
    int               peak_fill;
    int               ops_total;
    int               act_seen[4];
    int               err_seen[4];

    function new();
      fill      = 0;
      failures  = 0;
      checked   = 0;
      peak_fill = 0;
      ops_total = 0;
      foreach (act_seen[i]) act_seen[i] = 0;
      foreach (err_seen[i]) err_seen[i] = 0;
    endfunction

    // Pop the count entry and leave exactly 'want' arguments on top.
    function logic [ERR_W-1:0] adjust_args(logic [EXP_W-1:0] want);
      int n, c, sh, base, newfill, i;
      if (fill == 0) return ERR_UNDERFLOW;
      n = int'(fill) - 1;
      if (pay_mem[n] > n) return ERR_COUNT;
      c = int'(pay_mem[n]);
      newfill = n - c + int'(want);
      if (newfill > DEPTH_N) return ERR_OVERFLOW;
      base = n - c;
      if (c > int'(want)) begin
        sh = c - int'(want);
        for (i = 0; i < int'(want); i++) begin
          tag_mem[base + i] = tag_mem[base + sh + i];
          pay_mem[base + i] = pay_mem[base + sh + i];
        end
      end else if (c < int'(want)) begin
        sh = int'(want) - c;
        // move upward from the top down so nothing is overwritten early
        for (i = c; i > 0; i--) begin
          tag_mem[base + sh + i - 1] = tag_mem[base + i - 1];
          pay_mem[base + sh + i - 1] = pay_mem[base + i - 1];
        end
        for (i = 0; i < sh; i++) begin
          tag_mem[base + i] = TAG_NULL;
          pay_mem[base + i] = '0;
        end
      end
      fill = newfill;
      return ERR_NONE;
    endfunction

    function void note_op(logic [ACT_W-1:0] act, logic [TAG_W-1:0] ptag,
                          logic [PAY_W-1:0] ppay, logic [OFF_W-1:0] off,
                          logic [EXP_W-1:0] want);
      stack_out_t r;
      int idx;
      r = '0;
      case (act)
        ACT_PUSH: begin
          if (fill >= DEPTH_N) begin
            r.err = ERR_OVERFLOW;
          end else begin
            tag_mem[fill] = ptag;
            pay_mem[fill] = ppay;
            fill++;
          end
        end
        ACT_POP: begin
          if (fill == 0) begin
            r.err = ERR_UNDERFLOW;
          end else begin
            fill--;
            r.tag     = tag_mem[fill];
            r.payload = pay_mem[fill];
            r.found   = 1'b1;
          end
        end
        ACT_PEEK: begin
          if (off < fill) begin
            idx       = int'(fill) - 1 - int'(off);
            r.tag     = tag_mem[idx];
            r.payload = pay_mem[idx];
            r.found   = 1'b1;
          end
        end
        default: r.err = adjust_args(want);
      endcase
      r.fill = fill[FILL_W-1:0];
      pending_results.push_back(r);
      ops_total++;
      act_seen[act]++;
      err_seen[r.err]++;
      if (fill > peak_fill) peak_fill = fill;
    endfunction

    function void report_field(string fld, logic [PAY_W-1:0] exp_v, logic [PAY_W-1:0] act_v);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, exp_v, act_v);
      failures++;
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data, logic found);
      stack_out_t got, want;
      got.tag     = data[2:0];
      got.payload = data[66:3];
      got.err     = data[68:67];
      got.fill    = data[75:69];
      got.found   = found;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %0h", $time, got);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.tag != want.tag) report_field("tag", PAY_W'(want.tag), PAY_W'(got.tag));
      if (got.payload != want.payload) report_field("payload", want.payload, got.payload);
      if (got.found != want.found) report_field("found", PAY_W'(want.found), PAY_W'(got.found));
      if (got.err != want.err) report_field("error", PAY_W'(want.err), PAY_W'(got.err));
      if (got.fill != want.fill) report_field("fill", PAY_W'(want.fill), PAY_W'(got.fill));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [ACT_W-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  operand_stack_mirror board;
  int                  burst_left;
  int                  ready_left;
  int                  ready_mode;
  int                  ready_phase;
  int                  cycles;

  operand_stack_arg_adjust i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [PAY_W-1:0] rand_pay();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    if ($urandom_range(0, 9) == 0) return TAG_W'($urandom_range(6, 7));
    return TAG_W'($urandom_range(0, 5));
  endfunction

  // Send one operation; idle between bursts, then hold until accepted.
  task automatic send_op(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] ptag,
                         input logic [PAY_W-1:0] ppay, input logic [OFF_W-1:0] off,
                         input logic [EXP_W-1:0] want);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {want, off, ppay, ptag};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_op(act, ptag, ppay, off, want);
  endtask

  task automatic push_entry(input logic [TAG_W-1:0] ptag, input logic [PAY_W-1:0] ppay);
    send_op(ACT_PUSH, ptag, ppay, OFF_W'($urandom), EXP_W'($urandom));
  endtask

  task automatic pop_entry();
    send_op(ACT_POP, TAG_W'($urandom), rand_pay(), OFF_W'($urandom), EXP_W'($urandom));
  endtask

  task automatic peek_entry(input int off);
    send_op(ACT_PEEK, TAG_W'($urandom), rand_pay(), OFF_W'(off), EXP_W'($urandom));
  endtask

  task automatic adjust_op(input int want);
    send_op(ACT_ADJUST, TAG_W'($urandom), rand_pay(), OFF_W'($urandom), EXP_W'(want));
  endtask

  // Push arguments and a count, then adjust: the usual call shape.
  task automatic call_sequence();
    int nargs, cnt_sel, want;
    logic [PAY_W-1:0] cnt;
    if (board.fill > 48) repeat ($urandom_range(8, 30)) pop_entry();
    nargs = $urandom_range(0, 8);
    repeat (nargs) push_entry(rand_tag(), rand_pay());
    cnt_sel = $urandom_range(0, 19);
    case (cnt_sel)
      0:       cnt = rand_pay();
      1:       cnt = PAY_W'(board.fill);
      2:       cnt = PAY_W'(board.fill + 1);
      default: cnt = PAY_W'(nargs);
    endcase
    push_entry(rand_tag(), cnt);
    want = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 8);
    adjust_op(want);
    if ($urandom_range(0, 1) == 1) repeat ($urandom_range(0, want)) pop_entry();
  endtask

  task automatic single_op();
    case ($urandom_range(0, 3))
      0: push_entry(rand_tag(), rand_pay());
      1: pop_entry();
      2: begin
        if (board.fill > 0 && $urandom_range(0, 4) != 0)
          peek_entry($urandom_range(0, board.fill - 1));
        else
          peek_entry($urandom_range(0, 63));
      end
      default: adjust_op($urandom_range(0, 64));
    endcase
  endtask

  // Receiver: switch between stall patterns, each held for a random stretch.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 300);
    end
    ready_left--;
    ready_phase++;
    case (ready_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((ready_phase % 7) < 4);
    endcase
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycles,
             board.pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    board         = new();
    burst_left    = 0;
    ready_left    = 0;
    ready_mode    = 0;
    ready_phase   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_PUSH;
    m_axis_tready <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty stack: underflow on pop and adjust, miss on peek.
    pop_entry();
    adjust_op(3);
    peek_entry(0);
    push_entry(TAG_NULL, '0);
    push_entry(TAG_SPARE7, '1);
    push_entry(TAG_SPARE6, 64'hA5A5_A5A5_A5A5_A5A5);
    peek_entry(63);
    // Surplus: count 2, want 0, drops both arguments.
    push_entry(TAG_INT, 64'd2);
    adjust_op(0);
    // Shortfall: count 1, want 3, inserts two nulls beneath.
    push_entry(TAG_STRING, 64'd1);
    adjust_op(3);
    // Count larger than what lies beneath it.
    push_entry(TAG_FLOAT, '1);
    adjust_op(1);
    pop_entry();
    // Result would exceed the depth.
    push_entry(TAG_BOOL, '0);
    adjust_op(64);
    pop_entry();
    // Grow to exactly full, then overflow and read the bottom.
    push_entry(TAG_OBJECT, 64'd3);
    adjust_op(64);
    push_entry(TAG_INT, rand_pay());
    peek_entry(63);
    pop_entry();
    // Count covering everything, want none: empties the stack.
    push_entry(TAG_INT, 64'd63);
    adjust_op(0);

    while (board.ops_total < ITEMS) begin
      case ($urandom_range(0, 24))
        0: begin
          while (board.fill < DEPTH_N) push_entry(rand_tag(), rand_pay());
          push_entry(rand_tag(), rand_pay());
        end
        1: begin
          while (board.fill > 0) pop_entry();
          pop_entry();
        end
        2, 3, 4, 5, 6, 7, 8, 9: single_op();
        default: call_sequence();
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations (push %0d, pop %0d, peek %0d, adjust %0d), %0d results checked, peak fill %0d",
             board.ops_total, board.act_seen[ACT_PUSH], board.act_seen[ACT_POP],
             board.act_seen[ACT_PEEK], board.act_seen[ACT_ADJUST], board.checked,
             board.peak_fill);
    $display("Error codes seen: underflow %0d, overflow %0d, count too large %0d; %0d mismatches",
             board.err_seen[ERR_UNDERFLOW], board.err_seen[ERR_OVERFLOW],
             board.err_seen[ERR_COUNT], board.failures);
    if (board.failures == 0 && board.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
